### sv/vnsc_pkg.sv
// shared constants, types and palette for the nearest-seed colour block
`timescale 1ns / 1ps
package vnsc_pkg;

   localparam int SEED_MAX       = 8;
   localparam int SEED_COUNT_DEF = 8;
   localparam int COORD_W        = 10;
   localparam int SEED_W         = 2 * COORD_W;
   localparam int DIST_W         = COORD_W + 1;
   localparam int IDX_W          = $clog2(SEED_MAX);
   localparam int COLOUR_W       = 32;
   localparam int DATA_W         = 32;
   localparam int CSR_ADDR_W     = IDX_W + 2;
   localparam int PAIR_COUNT     = SEED_MAX / 2;
   localparam int QUAD_COUNT     = SEED_MAX / 4;

   typedef logic [COORD_W-1:0]                 coord_type;
   typedef logic [DIST_W-1:0]                  dist_type;
   typedef logic [IDX_W-1:0]                   idx_type;
   typedef logic [COLOUR_W-1:0]                colour_type;
   typedef logic [SEED_MAX-1:0][SEED_W-1:0]    seed_array_type;
   typedef logic [SEED_MAX-1:0][DIST_W-1:0]    dist_array_type;

   typedef struct packed {
      idx_type  idx;
      dist_type distance;
   } cand_type;

   localparam colour_type PALETTE [SEED_MAX] = '{
      32'h0d2b45FF, 32'h203c56FF, 32'h544e68FF, 32'h8d697aFF,
      32'hd08159FF, 32'hffaa5eFF, 32'hffd4a3FF, 32'hffecd6FF
   };

   function automatic coord_type abs_diff(coord_type a, coord_type b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   // lower index wins unless the higher one is strictly closer
   function automatic cand_type pick(cand_type lo, cand_type hi);
      return (hi.distance < lo.distance) ? hi : lo;
   endfunction

endpackage

### sv/vnsc_csr.sv
// seed position registers behind the apb-style configuration port
`timescale 1ns / 1ps
module vnsc_csr import vnsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready,
   output seed_array_type        seeds
);

   seed_array_type seed_ff, seed_in;
   idx_type        reg_idx;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;

   always_comb begin
      seed_in = seed_ff;
      if (psel && penable && pwrite && pready) begin
         seed_in[reg_idx] = pwdata[SEED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign prdata = DATA_W'(seed_ff[reg_idx]);
   assign seeds  = seed_ff;

endmodule

### sv/vnsc_dist.sv
// two pipeline stages: per-seed absolute differences, then manhattan distance
`timescale 1ns / 1ps
module vnsc_dist import vnsc_pkg::*; #(
   parameter int SEED_COUNT = SEED_COUNT_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  coord_type      pixel_column,
   input  coord_type      pixel_row,
   input  seed_array_type seeds,
   output logic           out_valid,
   input  logic           out_ready,
   output dist_array_type out_dist
);

   logic           s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic           s1_ready, s2_ready;
   coord_type      col_diff_ff [SEED_MAX];
   coord_type      col_diff_in [SEED_MAX];
   coord_type      row_diff_ff [SEED_MAX];
   coord_type      row_diff_in [SEED_MAX];
   dist_array_type dist_ff, dist_in;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      for (int i = 0; i < SEED_MAX; i++) begin
         col_diff_in[i] = abs_diff(pixel_column, seeds[i][SEED_W-1:COORD_W]);
         row_diff_in[i] = abs_diff(pixel_row, seeds[i][COORD_W-1:0]);
         // unused lanes sit above any real distance
         if (i < SEED_COUNT) begin
            dist_in[i] = DIST_W'(col_diff_ff[i]) + DIST_W'(row_diff_ff[i]);
         end else begin
            dist_in[i] = '1;
         end
      end
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         col_diff_ff <= col_diff_in;
         row_diff_ff <= row_diff_in;
      end
      if (s2_ready) begin
         dist_ff <= dist_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_dist  = dist_ff;

endmodule

### sv/vnsc_select.sv
// two pipeline stages: minimum-distance tree, palette lookup into the output register
`timescale 1ns / 1ps
module vnsc_select import vnsc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  dist_array_type in_dist,
   output logic           out_valid,
   input  logic           out_ready,
   output idx_type        region_index,
   output colour_type     region_colour
);

   logic       s3_valid_ff, s3_valid_in, s4_valid_ff, s4_valid_in;
   logic       s3_ready, s4_ready;
   cand_type   pair_ff [PAIR_COUNT];
   cand_type   pair_in [PAIR_COUNT];
   cand_type   quad    [QUAD_COUNT];
   cand_type   best;
   idx_type    index_ff, index_in;
   colour_type colour_ff, colour_in;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign in_ready = s3_ready;

   always_comb begin
      for (int p = 0; p < PAIR_COUNT; p++) begin
         pair_in[p] = pick('{idx: IDX_W'(2*p),   distance: in_dist[2*p]},
                           '{idx: IDX_W'(2*p+1), distance: in_dist[2*p+1]});
      end
      for (int q = 0; q < QUAD_COUNT; q++) begin
         quad[q] = pick(pair_ff[2*q], pair_ff[2*q+1]);
      end
      best      = pick(quad[0], quad[1]);
      index_in  = best.idx;
      colour_in = PALETTE[best.idx];
      s3_valid_in = s3_ready ? in_valid : s3_valid_ff;
      s4_valid_in = s4_ready ? s3_valid_ff : s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         pair_ff <= pair_in;
      end
      if (s4_ready) begin
         index_ff  <= index_in;
         colour_ff <= colour_in;
      end
   end

   assign out_valid     = s4_valid_ff;
   assign region_index  = index_ff;
   assign region_colour = colour_ff;

endmodule

### sv/voronoi_nearest_seed_colour.sv
// Top level of the nearest-seed region colour block. Each word on the req
// channel is a pixel coordinate; the rsp word carries the index of the seed at
// the smallest manhattan distance (lowest index on a tie) and its RGBA palette
// colour. A new word is taken every clock cycle unless back-pressure on rsp
// stalls the pipeline. Each result passes through four register stages (the
// first loads at the edge that accepts its request): absolute differences, distance
// sums, pairwise minimum, final minimum with the palette lookup. Each stage
// stalls only when it is full and the stage after it is held, so back-pressure
// on rsp loses and repeats nothing. Seed positions are
// written through the csr port, column in bits 19..10 and row in bits 9..0, at
// byte address 4 times the seed number; only the first SEED_COUNT seeds take
// part in the search. Write the seeds while no word is in flight.
`timescale 1ns / 1ps
module voronoi_nearest_seed_colour import vnsc_pkg::*; #(
   parameter int SEED_COUNT = SEED_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_W-1:0]    req_pixel_column,
   input  logic [COORD_W-1:0]    req_pixel_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_W-1:0]      rsp_region_index,
   output logic [COLOUR_W-1:0]   rsp_region_colour,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0]     csr_pwdata,
   output logic [DATA_W-1:0]     csr_prdata,
   output logic                  csr_pready
);

   seed_array_type seeds;
   logic           dist_valid, dist_ready;
   dist_array_type distances;

   vnsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .seeds   (seeds)
   );

   vnsc_dist #(.SEED_COUNT(SEED_COUNT)) u_dist (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .pixel_column (req_pixel_column),
      .pixel_row    (req_pixel_row),
      .seeds        (seeds),
      .out_valid    (dist_valid),
      .out_ready    (dist_ready),
      .out_dist     (distances)
   );

   vnsc_select u_select (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (dist_valid),
      .in_ready      (dist_ready),
      .in_dist       (distances),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .region_index  (rsp_region_index),
      .region_colour (rsp_region_colour)
   );

endmodule
